// ----- rtl/tmcc_pkg.sv -----
// shared constants and types for the tile mean color classifier
`timescale 1ns / 1ps
package tmcc_pkg;
  localparam int unsigned MaxTilesAcross = 64;
  localparam int unsigned MaxTileSide    = 256;
  localparam int unsigned MaxImageSide   = 4096;

  localparam int unsigned ColW   = $clog2(MaxTilesAcross);
  localparam int unsigned TileW  = $clog2(MaxTileSide);
  localparam int unsigned PixW   = $clog2(MaxImageSide);
  localparam int unsigned SumW   = 24;
  localparam int unsigned CntW   = 2 * TileW + 1;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TILE_WIDTH   = 3'd2,
    REG_TILE_HEIGHT  = 3'd3,
    REG_TILES_ACROSS = 3'd4,
    REG_TILES_DOWN   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_WHITE = 2'd0,
    CLS_BLACK = 2'd1,
    CLS_RED   = 2'd2,
    CLS_BLUE  = 2'd3
  } cell_class_e;

  // one finished tile, handed from the accumulator to the divider
  typedef struct packed {
    logic [ColW-1:0] row;
    logic [ColW-1:0] col;
    logic [SumW-1:0] sb;
    logic [SumW-1:0] sg;
    logic [SumW-1:0] sr;
    logic [CntW-1:0] cnt;
    logic            last;
  } tile_job_t;
endpackage

// ----- rtl/tile_mean_color_classifier_unit.sv -----
// top level of the tile mean color classifier
`timescale 1ns / 1ps
// Sums BGR pixels per tile in a 64-entry column memory (read-modify-write, one
// pixel per cycle unless stalled) and emits one beat per completed tile with its
// mean color and class. After reset the sum memory is cleared; after each frame's
// last pixel it is cleared again and no pixel is taken until that clear is done.
// Each tile's means are computed in the bit-serial divider; a tile's last pixel
// waits until the job register in front of the divider is free.
module tile_mean_color_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_blue, pixel_green, pixel_red
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tile_row, tile_col, mean_blue, mean_green, mean_red, cell_class, matched
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast   // frame_last
);
  logic [12:0] w_q, h_q;
  logic [8:0]  tw_q, th_q;
  logic [6:0]  ta_q, td_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= 13'd640; h_q <= 13'd480; tw_q <= 9'd20; th_q <= 9'd20;
      ta_q <= 7'd32; td_q <= 7'd24;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmcc_pkg::REG_IMAGE_WIDTH:  w_q  <= cfg_data_i;
        tmcc_pkg::REG_IMAGE_HEIGHT: h_q  <= cfg_data_i;
        tmcc_pkg::REG_TILE_WIDTH:   tw_q <= cfg_data_i[8:0];
        tmcc_pkg::REG_TILE_HEIGHT:  th_q <= cfg_data_i[8:0];
        tmcc_pkg::REG_TILES_ACROSS: ta_q <= cfg_data_i[6:0];
        tmcc_pkg::REG_TILES_DOWN:   td_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic jv, jr;
  tmcc_pkg::tile_job_t job;

  tmcc_accum u_accum (
    .clk_i, .rst_ni, .w_i(w_q), .h_i(h_q), .tw_i(tw_q), .th_i(th_q),
    .ta_i(ta_q), .td_i(td_q), .pix_valid_i(s_axis_tvalid), .pix_ready_o(s_axis_tready),
    .pix_i(s_axis_tdata), .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  tmcc_divide u_divide (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );
endmodule

// ----- rtl/tmcc_accum.sv -----
// per-column sum memory with read-modify-write and raster position tracking
`timescale 1ns / 1ps
module tmcc_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [12:0]                       w_i,
  input  logic [12:0]                       h_i,
  input  logic [8:0]                        tw_i,
  input  logic [8:0]                        th_i,
  input  logic [6:0]                        ta_i,
  input  logic [6:0]                        td_i,
  input  logic                              pix_valid_i,
  output logic                              pix_ready_o,
  input  logic [23:0]                       pix_i,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output tmcc_pkg::tile_job_t               job_o
);
  localparam int unsigned CW = tmcc_pkg::ColW;
  localparam int unsigned SW = tmcc_pkg::SumW;

  logic [3*SW-1:0] mem [tmcc_pkg::MaxTilesAcross];
  logic [3*SW-1:0] rd_q;
  logic            clr_busy_q, clr_busy_d;
  logic [CW-1:0]   clr_idx_q, clr_idx_d;
  logic            clr_all_q, clr_all_d;

  // stage 1 holds the pixel while its column entry is read
  logic            s1_q, s1_d;
  logic [23:0]     s1_pix_q;
  logic [CW-1:0]   s1_col_q, s1_row_q;
  logic            s1_emit_q, s1_last_q;
  logic [tmcc_pkg::TileW-1:0] s1_xt_q, s1_yt_q;

  logic [tmcc_pkg::PixW-1:0]  px_q, py_q;
  logic [tmcc_pkg::TileW-1:0] xt_q, yt_q;
  logic [CW-1:0]              gc_q, gr_q;
  logic                       coff_q, roff_q;

  // clamped registers
  logic [13:0] w, h;
  logic [9:0]  tw, th;
  logic [7:0]  ta, td;
  always_comb begin
    w  = (w_i == '0) ? 14'd1 : ((w_i > 13'd4096) ? 14'd4096 : {1'b0, w_i});
    h  = (h_i == '0) ? 14'd1 : ((h_i > 13'd4096) ? 14'd4096 : {1'b0, h_i});
    tw = (tw_i == '0) ? 10'd1 : ((tw_i > 9'd256) ? 10'd256 : {1'b0, tw_i});
    th = (th_i == '0) ? 10'd1 : ((th_i > 9'd256) ? 10'd256 : {1'b0, th_i});
    ta = (ta_i == '0) ? 8'd1 : ((ta_i > 7'd64) ? 8'd64 : {1'b0, ta_i});
    td = (td_i == '0) ? 8'd1 : ((td_i > 7'd64) ? 8'd64 : {1'b0, td_i});
  end

  logic row_end, frame_end, x_end, y_end, acc, emit_n;
  always_comb begin
    row_end   = ({2'b0, px_q} + 14'd1) >= w;
    frame_end = row_end && (({2'b0, py_q} + 14'd1) >= h);
    x_end     = row_end || (({2'b0, xt_q} + 10'd1) >= tw);
    y_end     = (({2'b0, py_q} + 14'd1) >= h) || (({2'b0, yt_q} + 10'd1) >= th);
    acc       = !coff_q && !roff_q;
    emit_n    = acc && x_end && y_end;
  end

  // an emitting pixel is taken only when the job slot is sure to be free
  // in the next cycle, and no pixel is taken while a clear is pending
  logic fire;
  assign pix_ready_o = !clr_busy_q && !clr_all_q &&
                       !(emit_n && ((job_valid_o && !job_ready_i) || (s1_q && s1_emit_q)));
  assign fire = pix_valid_i && pix_ready_o;

  // forward a write of the same column from stage 1
  logic [3*SW-1:0] cur;
  logic fwd_q;
  logic [3*SW-1:0] wb_q;
  assign cur = fwd_q ? wb_q : rd_q;

  function automatic logic [SW-1:0] sat(input logic [SW-1:0] a, input logic [7:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {{SW-7{1'b0}}, b};
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

  logic [SW-1:0] nb, ng, nr;
  logic [3*SW-1:0] wb_d;
  always_comb begin
    nb = sat(cur[SW-1:0], s1_pix_q[7:0]);
    ng = sat(cur[2*SW-1:SW], s1_pix_q[15:8]);
    nr = sat(cur[3*SW-1:2*SW], s1_pix_q[23:16]);
    wb_d = s1_emit_q ? '0 : {nr, ng, nb};
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) mem[clr_idx_q] <= '0;
    else if (s1_q) mem[s1_col_q] <= wb_d;
    rd_q <= mem[gc_q];
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_pix_q  <= pix_i;
      s1_col_q  <= gc_q;
      s1_row_q  <= gr_q;
      s1_emit_q <= emit_n;
      s1_last_q <= frame_end;
      s1_xt_q   <= xt_q;
      s1_yt_q   <= yt_q;
    end
    wb_q <= wb_d;
    if (s1_q && s1_emit_q) begin
      job_o.row  <= s1_row_q;
      job_o.col  <= s1_col_q;
      job_o.sb   <= nb;
      job_o.sg   <= ng;
      job_o.sr   <= nr;
      job_o.cnt  <= {1'b0, s1_xt_q} * {1'b0, s1_yt_q} + {1'b0, s1_xt_q} +
                    {1'b0, s1_yt_q} + 17'd1;
      job_o.last <= s1_last_q;
    end
  end

  assign s1_d = fire && acc;
  always_comb begin
    clr_all_d  = clr_all_q;
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (&clr_idx_q) clr_busy_d = 1'b0;
    end else if (clr_all_q && !s1_q) begin
      clr_busy_d = 1'b1;
      clr_all_d  = 1'b0;
    end
    if (fire && frame_end) clr_all_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0; fwd_q <= 1'b0; job_valid_o <= 1'b0;
      clr_busy_q <= 1'b1; clr_idx_q <= '0; clr_all_q <= 1'b0;
      px_q <= '0; py_q <= '0; xt_q <= '0; yt_q <= '0;
      gc_q <= '0; gr_q <= '0; coff_q <= 1'b0; roff_q <= 1'b0;
    end else begin
      s1_q <= s1_d;
      clr_busy_q <= clr_busy_d; clr_idx_q <= clr_idx_d; clr_all_q <= clr_all_d;
      fwd_q <= s1_q && s1_d && (s1_col_q == gc_q);
      if (s1_q && s1_emit_q) job_valid_o <= 1'b1;
      else if (job_ready_i) job_valid_o <= 1'b0;
      if (fire) begin
        if (frame_end) begin
          px_q <= '0; py_q <= '0; xt_q <= '0; yt_q <= '0;
          gc_q <= '0; gr_q <= '0; coff_q <= 1'b0; roff_q <= 1'b0;
        end else if (row_end) begin
          px_q <= '0; xt_q <= '0; gc_q <= '0; coff_q <= 1'b0;
          py_q <= py_q + 1'b1;
          if (({2'b0, yt_q} + 10'd1) >= th) begin
            yt_q <= '0;
            if (({2'b0, gr_q} + 8'd1) >= td) roff_q <= 1'b1;
            else gr_q <= gr_q + 1'b1;
          end else yt_q <= yt_q + 1'b1;
        end else begin
          px_q <= px_q + 1'b1;
          if (({2'b0, xt_q} + 10'd1) >= tw) begin
            xt_q <= '0;
            if (({2'b0, gc_q} + 8'd1) >= ta) coff_q <= 1'b1;
            else gc_q <= gc_q + 1'b1;
          end else xt_q <= xt_q + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pix_ready_o) else $error("pixel taken during clear");
  a_no_job_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q && s1_emit_q) |-> (!job_valid_o || job_ready_i)) else $error("job overrun");
  a_stage_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |-> $past(pix_valid_i && pix_ready_o)) else $error("stray stage");
`endif
endmodule

// ----- rtl/tmcc_divide.sv -----
// restoring divider for the three channel means plus classification
`timescale 1ns / 1ps
module tmcc_divide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  tmcc_pkg::tile_job_t job_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,
  output logic                m_axis_tlast
);
  localparam int unsigned SW = tmcc_pkg::SumW;
  localparam int unsigned CW = tmcc_pkg::CntW;

  logic            busy_q;
  logic [4:0]      step_q;
  tmcc_pkg::tile_job_t j_q;
  logic [CW:0]     rem_q [3];
  logic [SW-1:0]   quo_q [3];
  logic [SW-1:0]   num_q [3];

  assign job_ready_o = !busy_q && !m_axis_tvalid;

  logic [CW:0] rs [3];
  logic [CW:0] diff [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs[k]   = {rem_q[k][CW-1:0], num_q[k][SW-1]};
      diff[k] = rs[k] - {1'b0, j_q.cnt};
    end
  end

  function automatic logic [7:0] clip(input logic [SW-1:0] q);
    return (q > 24'd255) ? 8'd255 : q[7:0];
  endfunction

  logic [7:0] mb, mg, mr;
  logic [1:0] cls;
  logic hit;
  always_comb begin
    mb = clip(quo_q[0]); mg = clip(quo_q[1]); mr = clip(quo_q[2]);
    hit = 1'b1;
    cls = tmcc_pkg::CLS_WHITE;
    if (mb == 8'd255 && mg == 8'd255 && mr == 8'd255) cls = tmcc_pkg::CLS_WHITE;
    else if (mb == 8'd0 && mg == 8'd0 && mr == 8'd0) cls = tmcc_pkg::CLS_BLACK;
    else if (mb == 8'd0 && mg == 8'd0 && mr == 8'd255) cls = tmcc_pkg::CLS_RED;
    else if (mb == 8'd255 && mg == 8'd0 && mr == 8'd0) cls = tmcc_pkg::CLS_BLUE;
    else hit = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      j_q <= job_i;
      num_q[0] <= job_i.sb; num_q[1] <= job_i.sg; num_q[2] <= job_i.sr;
      for (int k = 0; k < 3; k++) begin rem_q[k] <= '0; quo_q[k] <= '0; end
    end else if (busy_q) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= num_q[k] << 1;
        if (!diff[k][CW]) begin
          rem_q[k] <= diff[k];
          quo_q[k] <= {quo_q[k][SW-2:0], 1'b1};
        end else begin
          rem_q[k] <= rs[k];
          quo_q[k] <= {quo_q[k][SW-2:0], 1'b0};
        end
      end
    end
    if (busy_q && step_q == 5'd23) m_axis_tdata <= '0;
    if (busy_q && step_q == 5'd24) begin
      m_axis_tdata <= {1'b0, hit, cls, mr, mg, mb, j_q.col, j_q.row};
      m_axis_tlast <= j_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; step_q <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      if (job_valid_i && job_ready_o) begin
        busy_q <= 1'b1; step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 5'd24) begin busy_q <= 1'b0; m_axis_tvalid <= 1'b1; end
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end
endmodule

// ----- dv/tile_mean_color_classifier_unit_tb.sv -----
// self-checking testbench for the tile mean color classifier top level
`timescale 1ns / 1ps
module tile_mean_color_classifier_unit_tb;

  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [7:0]  mb;
    logic [7:0]  mg;
    logic [7:0]  mr;
    tmcc_pkg::cell_class_e cls;
    logic        hit;
    logic        last;
  } tile_result_t;

  class tile_scoreboard;
    int unsigned img_w = 640, img_h = 480, tile_w = 20, tile_h = 20;
    int unsigned tiles_x = 32, tiles_y = 24;
    int unsigned acc_b[tmcc_pkg::MaxTilesAcross];
    int unsigned acc_g[tmcc_pkg::MaxTilesAcross];
    int unsigned acc_r[tmcc_pkg::MaxTilesAcross];
    int unsigned px, py, xt, yt, gc, gr;
    bit col_off, row_off;
    tile_result_t pending[$];
    int unsigned errors;

    function int unsigned clampv(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void clear_pos();
      for (int i = 0; i < tmcc_pkg::MaxTilesAcross; i++) begin
        acc_b[i] = 0; acc_g[i] = 0; acc_r[i] = 0;
      end
      px = 0; py = 0; xt = 0; yt = 0; gc = 0; gr = 0;
      col_off = 0; row_off = 0;
    endfunction

    function void write_reg(tmcc_pkg::reg_idx_e idx, logic [12:0] v);
      case (idx)
        tmcc_pkg::REG_IMAGE_WIDTH:  img_w = v;
        tmcc_pkg::REG_IMAGE_HEIGHT: img_h = v;
        tmcc_pkg::REG_TILE_WIDTH:   tile_w = v[8:0];
        tmcc_pkg::REG_TILE_HEIGHT:  tile_h = v[8:0];
        tmcc_pkg::REG_TILES_ACROSS: tiles_x = v[6:0];
        tmcc_pkg::REG_TILES_DOWN:   tiles_y = v[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned sat_mean(int unsigned s, int unsigned n);
      int unsigned m;
      m = s / n;
      return (m > 255) ? 255 : m;
    endfunction

    function void note_pixel(logic [23:0] d);
      int unsigned w, h, tw, th, ta, td, n;
      bit row_end, frame_end, x_end, y_end;
      tile_result_t e;
      w = clampv(img_w, tmcc_pkg::MaxImageSide);
      h = clampv(img_h, tmcc_pkg::MaxImageSide);
      tw = clampv(tile_w, tmcc_pkg::MaxTileSide);
      th = clampv(tile_h, tmcc_pkg::MaxTileSide);
      ta = clampv(tiles_x, tmcc_pkg::MaxTilesAcross);
      td = clampv(tiles_y, tmcc_pkg::MaxTilesAcross);
      row_end = (px + 1 >= w);
      frame_end = row_end && (py + 1 >= h);
      x_end = row_end || (xt + 1 >= tw);
      y_end = (py + 1 >= h) || (yt + 1 >= th);
      if (!col_off && !row_off && gc < tmcc_pkg::MaxTilesAcross) begin
        acc_b[gc] = (acc_b[gc] + d[7:0] > 24'hFFFFFF) ? 24'hFFFFFF : acc_b[gc] + d[7:0];
        acc_g[gc] = (acc_g[gc] + d[15:8] > 24'hFFFFFF) ? 24'hFFFFFF : acc_g[gc] + d[15:8];
        acc_r[gc] = (acc_r[gc] + d[23:16] > 24'hFFFFFF) ? 24'hFFFFFF : acc_r[gc] + d[23:16];
        if (x_end && y_end) begin
          n = (xt + 1) * (yt + 1);
          e.row = gr[5:0];
          e.col = gc[5:0];
          e.mb = 8'(sat_mean(acc_b[gc], n));
          e.mg = 8'(sat_mean(acc_g[gc], n));
          e.mr = 8'(sat_mean(acc_r[gc], n));
          e.hit = 1;
          if (e.mb == 255 && e.mg == 255 && e.mr == 255) e.cls = tmcc_pkg::CLS_WHITE;
          else if (e.mb == 0 && e.mg == 0 && e.mr == 0) e.cls = tmcc_pkg::CLS_BLACK;
          else if (e.mb == 0 && e.mg == 0 && e.mr == 255) e.cls = tmcc_pkg::CLS_RED;
          else if (e.mb == 255 && e.mg == 0 && e.mr == 0) e.cls = tmcc_pkg::CLS_BLUE;
          else begin
            e.cls = tmcc_pkg::CLS_WHITE;
            e.hit = 0;
          end
          e.last = frame_end;
          pending.push_back(e);
          acc_b[gc] = 0; acc_g[gc] = 0; acc_r[gc] = 0;
        end
      end
      if (frame_end) begin
        clear_pos();
      end else if (row_end) begin
        px = 0; xt = 0; gc = 0; col_off = 0; py++;
        if (yt + 1 >= th) begin
          yt = 0;
          if (gr + 1 >= td) row_off = 1;
          else gr++;
        end else begin
          yt++;
        end
      end else begin
        px++;
        if (xt + 1 >= tw) begin
          xt = 0;
          if (gc + 1 >= ta) col_off = 1;
          else gc++;
        end else begin
          xt++;
        end
      end
    endfunction

    function void check_tile(logic [39:0] d, logic lst);
      tile_result_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected tile beat: data=%h last=%b", d, lst);
        return;
      end
      e = pending.pop_front();
      bad = d[5:0] !== e.row || d[11:6] !== e.col || d[19:12] !== e.mb ||
            d[27:20] !== e.mg || d[35:28] !== e.mr || d[37:36] !== e.cls ||
            d[38] !== e.hit || d[39] !== 1'b0 || lst !== e.last;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("tile mismatch: exp row=%0d col=%0d bgr=%0d,%0d,%0d cls=%0d hit=%b last=%b",
                   e.row, e.col, e.mb, e.mg, e.mr, e.cls, e.hit, e.last,
                   " | got row=%0d col=%0d bgr=%0d,%0d,%0d cls=%0d hit=%b last=%b pad=%b",
                   d[5:0], d[11:6], d[19:12], d[27:20], d[35:28], d[37:36], d[38], lst,
                   d[39]);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  tile_mean_color_classifier_unit uut (.*);

  tile_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit hold_req = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // beat monitor: results come from earlier pixels, so check before noting
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_tile(m_axis_tdata, m_axis_tlast);
    if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int unsigned pct, phase, hold_left;
    pct = 0; phase = 0; hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (++phase >= 64) begin
        phase = 0;
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 60;
          default: pct = 90;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  task automatic push_pixel(logic [23:0] d);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_geometry(int unsigned w, h, tw, th, ta, td);
    logic [12:0] vals[6];
    vals = '{13'(w), 13'(h), 13'(tw), 13'(th), 13'(ta), 13'(td)};
    drain_and_idle();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1;
      cfg_idx_i <= i[2:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(tmcc_pkg::reg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 0;
  endtask

  function automatic logic [23:0] pick_pixel(int unsigned mode);
    logic [23:0] c[4];
    c = '{24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h0000FF};
    if (mode == 0) return c[$urandom_range(0, 3)];
    if (mode == 1) return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255))};
    return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
            {8{1'($urandom_range(0, 1))}}};
  endfunction

  // two side-by-side 2x2 tiles in a 4x2 image
  task automatic two_tiles(logic [23:0] a0, a1, b0, b1);
    for (int y = 0; y < 2; y++) begin
      push_pixel(a0); push_pixel(a1); push_pixel(b0); push_pixel(b1);
    end
  endtask

  initial begin
    int unsigned w, h, tw, th, ta, td, mode, sent;
    logic [23:0] solid;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    write_geometry(4, 2, 2, 2, 2, 1);
    two_tiles(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
    two_tiles(24'hFF0000, 24'hFF0000, 24'h0000FF, 24'h0000FF);
    two_tiles(24'h010203, 24'hFEFDFC, 24'hFFFFFF, 24'hFFFFFE);

    // zero registers count as one: one-pixel frames
    write_geometry(0, 0, 0, 0, 0, 0);
    push_pixel(24'hFFFFFF); push_pixel(24'h000000); push_pixel(24'h5AA5C3);

    // oversized tile registers clamp: full-size tiles and a partial one on one row
    write_geometry(520, 1, 511, 511, 127, 127);
    for (int i = 0; i < 520; i++) push_pixel(pick_pixel(i < 256 ? 0 : 1));

    // many small tiles under a long receiver hold, so the input stalls
    write_geometry(40, 1, 4, 1, 10, 1);
    hold_req = 1;
    for (int i = 0; i < 40; i++) push_pixel(pick_pixel(1));

    // grid smaller than the image: only the corner tile, no frame end marker
    write_geometry(3, 4, 1, 1, 1, 1);
    for (int i = 0; i < 12; i++) push_pixel(pick_pixel(1));
    // grid larger than the image
    write_geometry(2, 2, 8, 8, 64, 64);
    for (int i = 0; i < 4; i++) push_pixel(24'h0000FF);

    sent = 0;
    while (sent < 350) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      tw = $urandom_range(1, 6);
      th = $urandom_range(1, 6);
      if ($urandom_range(0, 9) < 7) begin
        ta = (w + tw - 1) / tw;
        td = (h + th - 1) / th;
      end else begin
        ta = $urandom_range(1, 4);
        td = $urandom_range(1, 4);
      end
      write_geometry(w, h, tw, th, ta, td);
      for (int f = 0; f < $urandom_range(1, 3); f++) begin
        mode = $urandom_range(0, 3);
        solid = pick_pixel(0);
        for (int i = 0; i < w * h; i++) push_pixel(mode == 3 ? solid : pick_pixel(mode));
        sent += w * h;
      end
    end

    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
